// ===== sv/wps_pkg.sv =====
// Shared widths, constants and types of the wheel pulse speedometer.
package wps_pkg;

  localparam int INTERVAL_BITS = 20;
  localparam int DISTANCE_BITS = 40;
  localparam int CIRC_BITS     = 12;
  localparam int SPEED_SCALE   = 360;
  localparam int SPEED_BITS    = CIRC_BITS + $clog2(SPEED_SCALE);
  localparam int STEP_BITS     = $clog2(SPEED_BITS);
  localparam int CIRC_RESET    = 2096;

  typedef logic [INTERVAL_BITS-1:0] interval_t;
  typedef logic [DISTANCE_BITS-1:0] distance_t;
  typedef logic [CIRC_BITS-1:0]     circ_t;
  typedef logic [SPEED_BITS-1:0]    speed_t;
  typedef logic [STEP_BITS-1:0]     step_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ===== sv/wps_in_if.sv =====
// Tick request channel carrying the sampled Hall sensor level.
interface wps_in_if;
  logic valid;
  logic ready;
  logic hall_level;

  modport source (output valid, output hall_level, input ready);
  modport sink (input valid, input hall_level, output ready);
endinterface

// ===== sv/wps_out_if.sv =====
// Result request channel carrying speed, distance and interval.
interface wps_out_if;
  logic               valid;
  logic               ready;
  wps_pkg::speed_t    speed_centi_kmh;
  wps_pkg::distance_t distance_mm;
  wps_pkg::interval_t interval_ticks;

  modport source (output valid, output speed_centi_kmh, output distance_mm,
                  output interval_ticks, input ready);
  modport sink (input valid, input speed_centi_kmh, input distance_mm,
                input interval_ticks, output ready);
endinterface

// ===== sv/wheel_pulse_speedometer_unit.sv =====
// Top level of the wheel pulse speedometer with its shared serial divider.
// A tick that gives no result is taken at once and ready stays high.
// A tick on an armed rising edge starts a restoring divider that produces one
// quotient bit per cycle (SPEED_BITS = 21 bits); in ST_DONE the result is loaded
// into the output register once no pending result is stalled there, and a new
// tick is taken in the following cycle.
// Synchronous active-low reset clears the counters, distance and arming and
// restores the circumference register to 2096 mm.
module wheel_pulse_speedometer_unit (
  input  logic            clk,
  input  logic            rst_n,
  wps_in_if.sink          in_if,
  wps_out_if.source       out_if,
  input  logic            cfg_we,
  input  wps_pkg::circ_t  cfg_wdata
);

  wps_pkg::state_t    state_r, state_nxt;
  wps_pkg::circ_t     circ_r, circ_nxt;
  logic               prev_level_r, prev_level_nxt;
  logic               armed_r, armed_nxt;
  wps_pkg::interval_t tick_r, tick_nxt;
  wps_pkg::distance_t dist_r, dist_nxt;

  // Divider datapath: remainder, shifting dividend/quotient, divisor.
  wps_pkg::interval_t rem_r, rem_nxt;
  wps_pkg::speed_t    quo_r, quo_nxt;
  wps_pkg::interval_t div_r, div_nxt;
  wps_pkg::step_t     cnt_r, cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  wps_pkg::speed_t    out_speed_r, out_speed_nxt;
  wps_pkg::distance_t out_dist_r, out_dist_nxt;
  wps_pkg::interval_t out_intv_r, out_intv_nxt;

  logic                               in_acc;
  logic                               rise;
  wps_pkg::interval_t                 tick_inc;
  logic [wps_pkg::DISTANCE_BITS:0]    dist_sum;
  wps_pkg::distance_t                 dist_sat;
  wps_pkg::speed_t                    dividend;
  logic [wps_pkg::INTERVAL_BITS:0]    trial;
  logic [wps_pkg::INTERVAL_BITS:0]    trial_diff;
  logic                               fits;

  assign in_if.ready = (state_r == wps_pkg::ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign rise        = in_if.hall_level && !prev_level_r;
  assign tick_inc    = (&tick_r) ? tick_r : tick_r + 1'b1;

  // Distance saturates at all ones when the add carries out.
  assign dist_sum = {1'b0, dist_r} + (wps_pkg::DISTANCE_BITS + 1)'(circ_r);
  assign dist_sat = dist_sum[wps_pkg::DISTANCE_BITS] ? '1
                                                     : dist_sum[wps_pkg::DISTANCE_BITS-1:0];
  assign dividend = wps_pkg::SPEED_BITS'(circ_r) *
                    wps_pkg::SPEED_BITS'(wps_pkg::SPEED_SCALE);

  assign trial      = {rem_r, quo_r[wps_pkg::SPEED_BITS-1]};
  assign trial_diff = trial - {1'b0, div_r};
  assign fits       = (trial >= {1'b0, div_r});

  assign out_if.valid           = out_valid_r;
  assign out_if.speed_centi_kmh = out_speed_r;
  assign out_if.distance_mm     = out_dist_r;
  assign out_if.interval_ticks  = out_intv_r;

  always_comb begin
    state_nxt      = state_r;
    circ_nxt       = cfg_we ? cfg_wdata : circ_r;
    prev_level_nxt = prev_level_r;
    armed_nxt      = armed_r;
    tick_nxt       = tick_r;
    dist_nxt       = dist_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    div_nxt        = div_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_speed_nxt  = out_speed_r;
    out_dist_nxt   = out_dist_r;
    out_intv_nxt   = out_intv_r;

    case (state_r)
      wps_pkg::ST_IDLE: begin
        if (in_acc) begin
          tick_nxt       = tick_inc;
          prev_level_nxt = in_if.hall_level;
          if (rise) begin
            tick_nxt = '0;
            if (armed_r) begin
              dist_nxt  = dist_sat;
              div_nxt   = tick_inc;
              quo_nxt   = dividend;
              rem_nxt   = '0;
              cnt_nxt   = wps_pkg::STEP_BITS'(wps_pkg::SPEED_BITS - 1);
              state_nxt = wps_pkg::ST_DIV;
            end else begin
              armed_nxt = 1'b1;
            end
          end
        end
      end
      wps_pkg::ST_DIV: begin
        // One restoring step: the remainder stays below the divisor, so it
        // fits back into the interval width after the subtract.
        rem_nxt = fits ? trial_diff[wps_pkg::INTERVAL_BITS-1:0]
                       : trial[wps_pkg::INTERVAL_BITS-1:0];
        quo_nxt = {quo_r[wps_pkg::SPEED_BITS-2:0], fits};
        if (cnt_r == '0) begin
          state_nxt = wps_pkg::ST_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      wps_pkg::ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_speed_nxt = quo_r;
          out_dist_nxt  = dist_r;
          out_intv_nxt  = div_r;
          state_nxt     = wps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wps_pkg::ST_IDLE;
      circ_r       <= wps_pkg::CIRC_BITS'(wps_pkg::CIRC_RESET);
      prev_level_r <= 1'b0;
      armed_r      <= 1'b0;
      tick_r       <= '0;
      dist_r       <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      circ_r       <= circ_nxt;
      prev_level_r <= prev_level_nxt;
      armed_r      <= armed_nxt;
      tick_r       <= tick_nxt;
      dist_r       <= dist_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    div_r       <= div_nxt;
    out_speed_r <= out_speed_nxt;
    out_dist_r  <= out_dist_nxt;
    out_intv_r  <= out_intv_nxt;
  end

  a_edge_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && rise && armed_r) |=> (state_r == wps_pkg::ST_DIV))
    else $error("armed rising edge did not start the divider");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wps_pkg::ST_DIV) |-> (div_r != '0))
    else $error("divider running with a zero interval");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wps_pkg::ST_DIV || state_r == wps_pkg::ST_DONE) |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  a_dist_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (dist_r >= $past(dist_r)))
    else $error("distance decreased");

  a_no_load_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |=> $stable(out_dist_r))
    else $error("pending result overwritten");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the wheel pulse speedometer unit.
`timescale 1ns / 1ps

module testbench;

  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 6;
  localparam int PHASE_TICKS  = 280;
  localparam int CALM_TICKS   = 150;
  localparam int LONG_GAP     = 100;

  localparam wps_pkg::distance_t ODOMETER_MAX = '1;
  localparam wps_pkg::interval_t TICKS_MAX    = '1;

  typedef struct packed {
    wps_pkg::speed_t    speed;
    wps_pkg::distance_t distance;
    wps_pkg::interval_t interval;
  } speed_report_t;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           cfg_we    = 1'b0;
  wps_pkg::circ_t cfg_wdata = '0;

  wps_in_if  tick_ch ();
  wps_out_if speed_ch ();

  wheel_pulse_speedometer_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (tick_ch),
    .out_if   (speed_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Own copy of the block state, advanced once per accepted tick.
  wps_pkg::circ_t     wheel_circ   = wps_pkg::circ_t'(wps_pkg::CIRC_RESET);
  logic               level_q      = 1'b0;
  logic               armed_q      = 1'b0;
  wps_pkg::interval_t ticks_q      = '0;
  wps_pkg::distance_t odometer_mm  = '0;

  bit            pending_levels[$];
  speed_report_t expected_reports[$];

  int send_idle_pct   = 0;
  int accept_idle_pct = 0;
  int send_gap        = 0;
  int accept_stall    = 0;
  int quiet_cycles    = 0;
  int mismatches      = 0;
  int ticks_taken     = 0;
  int reports_seen    = 0;
  int settings_used   = 0;

  function automatic void advance_tick(input logic level);
    longint unsigned speed;
    speed_report_t   rep;
    if (ticks_q != TICKS_MAX) ticks_q = ticks_q + 1'b1;
    if (level && !level_q) begin
      if (armed_q) begin
        // The count is at least one here: it was just incremented or held at its maximum.
        speed = (64'(wheel_circ) * wps_pkg::SPEED_SCALE) / 64'(ticks_q);
        if (ODOMETER_MAX - odometer_mm < wps_pkg::distance_t'(wheel_circ)) begin
          odometer_mm = ODOMETER_MAX;
        end else begin
          odometer_mm = odometer_mm + wps_pkg::distance_t'(wheel_circ);
        end
        rep.speed    = wps_pkg::speed_t'(speed);
        rep.distance = odometer_mm;
        rep.interval = ticks_q;
        expected_reports.push_back(rep);
      end else begin
        armed_q = 1'b1;
      end
      ticks_q = '0;
      level_q = 1'b1;
    end else if (!level) begin
      level_q = 1'b0;
    end
  endfunction

  // Tick sender.
  always @(posedge clk) begin
    logic handed_over;
    if (!rst_n) begin
      tick_ch.valid      <= 1'b0;
      tick_ch.hall_level <= 1'b0;
      send_gap           <= 0;
    end else begin
      handed_over = tick_ch.valid && tick_ch.ready;
      if (handed_over) void'(pending_levels.pop_front());
      // A request stays on the channel until it is taken.
      if (!tick_ch.valid || handed_over) begin
        if (send_gap != 0) begin
          send_gap      <= send_gap - 1;
          tick_ch.valid <= 1'b0;
        end else if (pending_levels.size() != 0 && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap      <= $urandom_range(0, 8);
          tick_ch.valid <= 1'b0;
        end else if (pending_levels.size() != 0) begin
          tick_ch.valid      <= 1'b1;
          tick_ch.hall_level <= pending_levels[0];
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Observes both channels: predicts on taken ticks, checks taken results.
  always @(posedge clk) begin
    speed_report_t want;
    if (!rst_n) begin
      speed_ch.ready <= 1'b0;
      accept_stall   <= 0;
    end else begin
      if (tick_ch.valid && tick_ch.ready) begin
        advance_tick(tick_ch.hall_level);
        ticks_taken++;
      end
      if (speed_ch.valid && speed_ch.ready) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: speed %0d distance %0d interval %0d",
                     speed_ch.speed_centi_kmh, speed_ch.distance_mm, speed_ch.interval_ticks);
        end else begin
          want = expected_reports.pop_front();
          if (want.speed !== speed_ch.speed_centi_kmh || want.distance !== speed_ch.distance_mm ||
              want.interval !== speed_ch.interval_ticks) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected speed %0d distance %0d interval %0d, got %0d %0d %0d",
                       reports_seen, want.speed, want.distance, want.interval,
                       speed_ch.speed_centi_kmh, speed_ch.distance_mm, speed_ch.interval_ticks);
          end
        end
      end
      if (accept_stall != 0) begin
        accept_stall   <= accept_stall - 1;
        speed_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < accept_idle_pct) begin
        accept_stall   <= $urandom_range(0, 8);
        speed_ch.ready <= 1'b0;
      end else begin
        speed_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (tick_ch.valid && tick_ch.ready) || (speed_ch.valid && speed_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("wheel_pulse_speedometer_unit: mismatch");
        $finish;
      end
    end
  end

  task automatic queue_pattern(input string levels);
    for (int i = 0; i < levels.len(); i++) pending_levels.push_back(levels[i] == "1");
  endtask

  // Mostly clean low/high pulses with random widths, some random noise between.
  task automatic queue_pulse_train(input int budget);
    int added;
    int low_len;
    int high_len;
    int k;
    added = 0;
    while (added < budget) begin
      if ($urandom_range(0, 4) == 0) begin
        k = $urandom_range(1, 12);
        repeat (k) pending_levels.push_back(1'($urandom_range(0, 1)));
      end else begin
        low_len  = ($urandom_range(0, 24) == 0) ? $urandom_range(10, 120) : $urandom_range(1, 6);
        high_len = $urandom_range(1, 5);
        k        = low_len + high_len;
        repeat (low_len) pending_levels.push_back(1'b0);
        repeat (high_len) pending_levels.push_back(1'b1);
      end
      added += k;
    end
  endtask

  // Waits until every tick is taken and every result checked.
  task automatic drain_requests();
    do @(negedge clk);
    while (pending_levels.size() != 0 || tick_ch.valid || expected_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_circumference(input wps_pkg::circ_t value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    wheel_circ = value;
    settings_used++;
    @(negedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset circumference: arming edge, shortest interval, level held high.
    @(negedge clk);
    send_idle_pct   = 10;
    accept_idle_pct = 10;
    queue_pattern("0101110001");
    drain_requests();
    set_circumference('0);
    queue_pattern("01");
    drain_requests();
    set_circumference('1);
    queue_pattern("01");
    drain_requests();
    set_circumference(wps_pkg::circ_t'(1));
    queue_pattern("0001");
    drain_requests();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1:       set_circumference(wps_pkg::circ_t'(1));
        2:       set_circumference('1);
        4:       set_circumference(wps_pkg::circ_t'(2048));
        default: set_circumference(wps_pkg::circ_t'($urandom_range(1, 4095)));
      endcase
      send_idle_pct   = (p == 1) ? 0 : ((p == 4) ? 30 : 12);
      accept_idle_pct = (p == 2) ? 0 : ((p == 4) ? 30 : 15);
      queue_pulse_train(PHASE_TICKS);
      drain_requests();
    end

    // Closing part without idling: a long low gap, then ordinary pulses.
    set_circumference('1);
    send_idle_pct   = 0;
    accept_idle_pct = 0;
    repeat (LONG_GAP) pending_levels.push_back(1'b0);
    pending_levels.push_back(1'b1);
    queue_pulse_train(CALM_TICKS);
    drain_requests();

    $display("Sent %0d ticks and checked %0d speed results over %0d circumference settings,",
             ticks_taken, reports_seen, settings_used);
    $display("with arming, held levels, zero and full circumference and a long low gap.");
    if (mismatches == 0) begin
      $display("wheel_pulse_speedometer_unit: match");
    end else begin
      $display("wheel_pulse_speedometer_unit: mismatch");
    end
    $finish;
  end

endmodule
